FILE: hdl/vbpc_pkg.sv
// Package: shared types, constants and codes of the bitmap pixel converter.
`default_nettype none
package vbpc_pkg;

  localparam int PIXEL_BITS  = 32;
  localparam int SMALL_DEPTH = 16;
  localparam int LARGE_DEPTH = 256;
  localparam int SMALL_AW    = $clog2(SMALL_DEPTH);
  localparam int LARGE_AW    = $clog2(LARGE_DEPTH);

  typedef logic [PIXEL_BITS-1:0] pix_t;

  typedef enum logic [1:0] {
    OP_CONVERT  = 2'd0,
    OP_WR_SMALL = 2'd1,
    OP_WR_LARGE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_DISPLAY_MODE = 2'd0,
    REG_ZOOM_MODE    = 2'd1,
    REG_BLEND_ENABLE = 2'd2,
    REG_BLEND_MASK   = 2'd3
  } reg_idx_t;

  localparam logic [2:0] MODE_G4 = 3'd0;
  localparam logic [2:0] MODE_G5 = 3'd1;
  localparam logic [2:0] MODE_G6 = 3'd2;
  localparam logic [2:0] MODE_G7 = 3'd3;

  localparam logic [1:0] ZOOM_NARROW = 2'd0;
  localparam logic [1:0] ZOOM_DOUBLE = 2'd1;

  typedef enum logic [1:0] {
    STEP_EMIT  = 2'd0,
    STEP_HOLD  = 2'd1,
    STEP_BLEND = 2'd2
  } step_kind_t;

  typedef struct packed {
    logic [2:0]  display_mode;
    logic [1:0]  zoom_mode;
    logic        blend_enable;
    logic [31:0] blend_mask;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    step_kind_t kind;
    logic       dup;
    logic       last;
    logic       lg_sel;
  } step_t;

  typedef struct packed {
    logic                we;
    logic [LARGE_AW-1:0] waddr;
    pix_t                wdata;
    logic                re;
    logic [LARGE_AW-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

FILE: hdl/vbpc_if.sv
// Interfaces: input item, result item and configuration write channels.
`default_nettype none
interface vbpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;
  logic [7:0]  entry_index;
  logic [31:0] entry_value;
  modport source (output valid, op, first_byte, second_byte, entry_index, entry_value,
                  input ready);
  modport sink (input valid, op, first_byte, second_byte, entry_index, entry_value,
                output ready);
endinterface

interface vbpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel;
  logic        last;
  modport source (output valid, pixel, last, input ready);
  modport sink (input valid, pixel, last, output ready);
endinterface

interface vbpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/vbpc_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
`default_nettype none
module vbpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/vbpc_issue.sv
// Issue stage: accepts items, writes palettes and sequences palette reads.
`default_nettype none
module vbpc_issue import vbpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  vbpc_in_if.sink    px_in,
  input  wire logic  advance,
  output step_t      step,
  output ram_req_t   sm_req,
  output ram_req_t   lg_req
);

  logic       busy;
  logic [1:0] cnt;
  logic [7:0] b0;
  logic [7:0] b1;
  logic       in_acc;
  logic       at_last;
  logic [1:0] last_cnt;
  logic       z256;
  logic       z512;
  logic       pair;
  logic [LARGE_AW-1:0] raddr;
  op_t        op;

  assign op   = op_t'(px_in.op);
  assign z256 = (cfg.zoom_mode == ZOOM_NARROW);
  assign z512 = (cfg.zoom_mode == ZOOM_DOUBLE);

  always_comb begin
    step.valid  = busy;
    step.kind   = STEP_EMIT;
    step.dup    = z512;
    step.lg_sel = 1'b0;
    last_cnt    = 2'd1;
    pair        = 1'b0;
    raddr       = '0;
    case (cfg.display_mode)
      MODE_G4: begin
        raddr = LARGE_AW'(cnt[0] ? b0[3:0] : b0[7:4]);
      end
      MODE_G5: begin
        last_cnt = 2'd3;
        pair     = z256;
        step.dup = 1'b0;
        case (cnt)
          2'd0:    raddr = LARGE_AW'(b0[7:6]);
          2'd1:    raddr = LARGE_AW'(b0[5:4]);
          2'd2:    raddr = LARGE_AW'(b0[3:2]);
          default: raddr = LARGE_AW'(b0[1:0]);
        endcase
      end
      MODE_G6: begin
        last_cnt = 2'd3;
        pair     = z256;
        step.dup = 1'b0;
        case (cnt)
          2'd0:    raddr = LARGE_AW'(b0[7:4]);
          2'd1:    raddr = LARGE_AW'(b0[3:0]);
          2'd2:    raddr = LARGE_AW'(b1[7:4]);
          default: raddr = LARGE_AW'(b1[3:0]);
        endcase
      end
      MODE_G7: begin
        step.lg_sel = 1'b1;
        raddr       = cnt[0] ? b1 : b0;
      end
      default: begin
        raddr = '0;
      end
    endcase
    if (pair) begin
      step.kind = cnt[0] ? STEP_BLEND : STEP_HOLD;
    end
    at_last   = (cnt == last_cnt);
    step.last = at_last;
  end

  assign px_in.ready = !busy || (advance && at_last);
  assign in_acc      = px_in.valid && px_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (in_acc) begin
      busy <= (op == OP_CONVERT);
      cnt  <= 2'd0;
    end else if (busy && advance) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b0 <= px_in.first_byte;
      b1 <= px_in.second_byte;
    end
  end

  always_comb begin
    sm_req.we    = in_acc && (op == OP_WR_SMALL);
    sm_req.waddr = LARGE_AW'(px_in.entry_index[SMALL_AW-1:0]);
    sm_req.wdata = px_in.entry_value[PIXEL_BITS-1:0];
    sm_req.re    = busy && advance && !step.lg_sel;
    sm_req.raddr = raddr;
    lg_req.we    = in_acc && (op == OP_WR_LARGE);
    lg_req.waddr = px_in.entry_index;
    lg_req.wdata = px_in.entry_value[PIXEL_BITS-1:0];
    lg_req.re    = busy && advance && step.lg_sel;
    lg_req.raddr = raddr;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt <= last_cnt))
    else $error("step counter beyond last step");

  a_one_read: assert property (@(posedge clk) disable iff (rst)
    !(sm_req.re && lg_req.re))
    else $error("both palettes read in one cycle");

  a_convert_load: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (op == OP_CONVERT)) |=> (busy && (cnt == 2'd0)))
    else $error("convert transaction not loaded");

endmodule
`default_nettype wire

FILE: hdl/vbpc_output.sv
// Data and output stage: palette read return, colour blend and pixel register.
`default_nettype none
module vbpc_output import vbpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire step_t step,
  input  wire pix_t  sm_rdata,
  input  wire pix_t  lg_rdata,
  output logic       advance,
  vbpc_out_if.source px_out
);

  step_t             d;
  pix_t              c1;
  logic              held;
  pix_t              o_pixel;
  logic              o_valid;
  logic              o_last;
  logic              dup;
  pix_t              rd;
  pix_t              mask;
  pix_t              c2;
  logic [PIXEL_BITS:0] sum;
  pix_t              val;
  logic              consume;
  logic              push;

  assign advance = !o_valid || (px_out.ready && !dup);
  assign consume = d.valid && advance;
  assign push    = consume && (d.kind != STEP_HOLD);

  always_comb begin
    rd   = d.lg_sel ? lg_rdata : sm_rdata;
    mask = cfg.blend_mask[PIXEL_BITS-1:0];
    c2   = (rd & ~mask) | (c1 & mask);
    sum  = {1'b0, c1} + {1'b0, c2};
    val  = rd;
    if (d.kind == STEP_BLEND) begin
      val = cfg.blend_enable ? sum[PIXEL_BITS:1] : c1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d <= '0;
    end else if (advance) begin
      d <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (consume && (d.kind == STEP_HOLD)) begin
      held <= 1'b1;
    end else if (consume && (d.kind == STEP_BLEND)) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && (d.kind == STEP_HOLD)) begin
      c1 <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      dup     <= 1'b0;
    end else if (push) begin
      o_valid <= 1'b1;
      dup     <= d.dup;
    end else if (o_valid && px_out.ready) begin
      if (dup) begin
        dup <= 1'b0;
      end else begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      o_pixel <= val;
      o_last  <= d.last;
    end
  end

  assign px_out.valid = o_valid;
  assign px_out.pixel = 32'(o_pixel);
  assign px_out.last  = o_last && !dup;

  a_dup_valid: assert property (@(posedge clk) disable iff (rst)
    dup |-> o_valid)
    else $error("repeat pending without a pixel");

  a_blend_held: assert property (@(posedge clk) disable iff (rst)
    (consume && (d.kind == STEP_BLEND)) |-> held)
    else $error("blend without a held first colour");

  a_hold_no_push: assert property (@(posedge clk) disable iff (rst)
    (consume && (d.kind == STEP_HOLD) && o_valid && !px_out.ready) |=> $stable(o_pixel))
    else $error("held colour disturbed a waiting pixel");

endmodule
`default_nettype wire

FILE: hdl/vdp_bitmap_pixel_converter.sv
// Top level: configuration registers, palette RAMs, issue and output stages.
// Paired modes hold the first colour read from a palette and push one pixel per pair.
// One palette read and at most one pixel per cycle while the output stage advances; the
// next item is taken with the last read of the current one. Palette writes give no pixel.
// Reset: configuration returns to defaults and the pipeline empties; palette RAMs
// are not cleared and hold undefined data until written.
`default_nettype none
module vdp_bitmap_pixel_converter import vbpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  vbpc_in_if.sink    px_in,
  vbpc_out_if.source px_out,
  vbpc_cfg_if.sink   cfg
);

  cfg_t     cfg_reg;
  step_t    step;
  ram_req_t sm_req;
  ram_req_t lg_req;
  pix_t     sm_rdata;
  pix_t     lg_rdata;
  logic     advance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.display_mode <= MODE_G4;
      cfg_reg.zoom_mode    <= ZOOM_NARROW;
      cfg_reg.blend_enable <= 1'b1;
      cfg_reg.blend_mask   <= 32'd0;
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.index))
        REG_DISPLAY_MODE: cfg_reg.display_mode <= cfg.data[2:0];
        REG_ZOOM_MODE:    cfg_reg.zoom_mode    <= cfg.data[1:0];
        REG_BLEND_ENABLE: cfg_reg.blend_enable <= cfg.data[0];
        REG_BLEND_MASK:   cfg_reg.blend_mask   <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  vbpc_issue u_issue (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_reg),
    .px_in   (px_in),
    .advance (advance),
    .step    (step),
    .sm_req  (sm_req),
    .lg_req  (lg_req)
  );

  vbpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(SMALL_DEPTH)) u_small_ram (
    .clk   (clk),
    .we    (sm_req.we),
    .waddr (sm_req.waddr[SMALL_AW-1:0]),
    .wdata (sm_req.wdata),
    .re    (sm_req.re),
    .raddr (sm_req.raddr[SMALL_AW-1:0]),
    .rdata (sm_rdata)
  );

  vbpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(LARGE_DEPTH)) u_large_ram (
    .clk   (clk),
    .we    (lg_req.we),
    .waddr (lg_req.waddr),
    .wdata (lg_req.wdata),
    .re    (lg_req.re),
    .raddr (lg_req.raddr),
    .rdata (lg_rdata)
  );

  vbpc_output u_output (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_reg),
    .step     (step),
    .sm_rdata (sm_rdata),
    .lg_rdata (lg_rdata),
    .advance  (advance),
    .px_out   (px_out)
  );

endmodule
`default_nettype wire
